// ===== src/owa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owa_pkg
// Shared types and constants for the weighted-window odometry integrator.
// ----------------------------------------------------------------------------
package owa_pkg;

  localparam int WINDOW       = 500;
  localparam int SLOT_W       = $clog2(WINDOW);
  localparam int FILL_W       = $clog2(WINDOW + 1);
  localparam int RATE_W       = 16;
  localparam int ROW_W        = 3 * RATE_W;
  localparam int STAMP_W      = 32;
  localparam int POS_W        = 32;
  localparam int HEAD_W       = 16;
  localparam int GAIN_W       = 16;
  localparam int INTERVAL_W   = 20;
  localparam int CFG_DATA_W   = 20;
  localparam int CFG_INDEX_W  = 2;

  // Window weight total: 1 + 2 + ... + WINDOW
  localparam int WSUM         = WINDOW * (WINDOW + 1) / 2;
  // Q.20 rate times microseconds into Q16.16 metres / binary-angle units
  localparam int POS_DIV      = 16000000;
  localparam int HEAD_DIV     = 100530965;
  localparam int DT_MAX       = 1048575;

  localparam int DIV_BITS     = 48;
  localparam int DIV_CNT_W    = $clog2(DIV_BITS);
  localparam int DEN_W        = 27;

  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_START = 9949;
  localparam int CORD_W       = 18;
  localparam int ANG_W        = 17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POS_GAIN     = 2'd0,
    REG_ROT_GAIN     = 2'd1,
    REG_MIN_INTERVAL = 2'd2
  } cfg_reg_t;

  typedef logic signed [RATE_W-1:0] rate_t;

  // atan(2^-i) in binary-angle units
  function automatic logic signed [ANG_W-1:0] atan_units(input logic [3:0] i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      4'd0:    r = 17'sd8192;
      4'd1:    r = 17'sd4836;
      4'd2:    r = 17'sd2555;
      4'd3:    r = 17'sd1297;
      4'd4:    r = 17'sd651;
      4'd5:    r = 17'sd326;
      4'd6:    r = 17'sd163;
      4'd7:    r = 17'sd81;
      4'd8:    r = 17'sd41;
      4'd9:    r = 17'sd20;
      4'd10:   r = 17'sd10;
      4'd11:   r = 17'sd5;
      4'd12:   r = 17'sd3;
      4'd13:   r = 17'sd1;
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/owa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owa_if
// Sample and pose channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface owa_sample_if;
  import owa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STAMP_W-1:0]   stamp_us;
  rate_t                body_vel_x;
  rate_t                body_vel_y;
  rate_t                yaw_rate;

  modport source (output valid, stamp_us, body_vel_x, body_vel_y, yaw_rate,
                  input ready);
  modport sink   (input valid, stamp_us, body_vel_x, body_vel_y, yaw_rate,
                  output ready);
endinterface

interface owa_pose_if;
  import owa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pose_x;
  logic signed [POS_W-1:0]  pose_y;
  logic [HEAD_W-1:0]        pose_heading;
  logic [STAMP_W-1:0]       pose_stamp_us;

  modport source (output valid, pose_x, pose_y, pose_heading, pose_stamp_us,
                  input ready);
  modport sink   (input valid, pose_x, pose_y, pose_heading, pose_stamp_us,
                  output ready);
endinterface
`default_nettype wire

// ===== src/owa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module owa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/odometry_integrator_weighted_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odometry_integrator_weighted_window
// Dead reckoning from body-frame velocity samples, smoothed by linearly
// weighted moving-average windows.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake        Payload
// sample    in   valid/ready      stamp_us, body_vel_x, body_vel_y, yaw_rate
// pose      out  valid/ready      pose_x, pose_y, pose_heading, pose_stamp_us
// cfg       in   cfg_wen          cfg_index, cfg_wdata
//
// First and dropped samples leave the block in idle. A kept sample runs the
// CORDIC steps, the rotation products and the window update; once the window
// is full, six 48-bit bit-serial divisions (one quotient bit per cycle) run
// before the pose is emitted. No new sample is taken until back in idle.
// Reset (rst, synchronous) clears pose, sums and counters; window RAM is not
// cleared. A pose waiting on pose.ready does not block the next sample.
// ----------------------------------------------------------------------------
module odometry_integrator_weighted_window (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wen,
  input  wire logic [owa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [owa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  owa_sample_if.sink                          sample,
  owa_pose_if.source                          pose
);
  import owa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CORD, S_ROT, S_RND, S_SUMS, S_MSTART, S_MDIV,
    S_MULG, S_MQ, S_MULT, S_SSTART, S_SDIV, S_FIN
  } state_t;

  state_t state;

  // configuration
  logic [GAIN_W-1:0]     pos_gain;
  logic [GAIN_W-1:0]     rot_gain;
  logic [INTERVAL_W-1:0] min_interval;

  // pose state
  logic signed [POS_W-1:0] world_x;
  logic signed [POS_W-1:0] world_y;
  logic [HEAD_W-1:0]       heading;
  logic [STAMP_W-1:0]      last_stamp;
  logic                    seen_first;
  logic [FILL_W-1:0]       fill_count;
  logic [SLOT_W-1:0]       write_slot;
  logic signed [24:0]      plain_sums [3];
  logic signed [35:0]      weighted_sums [3];

  // per-sample working registers
  logic [STAMP_W-1:0]      stamp;
  rate_t                   vx, vy;
  rate_t                   wv [3];
  logic [INTERVAL_W-1:0]   dt;
  logic [5:0]              cnt;
  logic [1:0]              ch;
  logic                    flip;
  logic signed [CORD_W-1:0] cx, cy;
  logic signed [ANG_W-1:0]  ca;
  logic signed [33:0]      accx, accy;
  logic [ROW_W-1:0]        old_row;
  logic signed [17:0]      mean;
  logic signed [24:0]      q;
  logic signed [23:0]      steps [3];
  logic signed [45:0]      prod;

  // divider
  logic                    div_neg;
  logic [DIV_BITS-1:0]     div_quo;
  logic [DEN_W-1:0]        div_rem;
  logic [DEN_W-1:0]        div_den;

  // output register
  logic                    out_valid;
  logic                    out_load;

  logic [ROW_W-1:0]        ram_rdata;
  logic                    ram_we;

  // ------------------------------------------------------------------
  // helpers
  function automatic rate_t sat_round14(input logic signed [33:0] n);
    logic [33:0] a;
    logic [33:0] m;
    rate_t       r;
    a = n[33] ? 34'(-n) : 34'(n);
    m = (a + 34'd8192) >> 14;
    if (!n[33]) begin
      r = (m > 34'd32767) ? 16'sh7fff : rate_t'(m[15:0]);
    end else begin
      r = (m > 34'd32768) ? 16'sh8000 : rate_t'(-m[15:0]);
    end
    return r;
  endfunction

  // ------------------------------------------------------------------
  // sample admission
  logic [STAMP_W-1:0]    diff;
  logic                  keep;
  logic signed [ANG_W-1:0] ha;
  logic signed [ANG_W-1:0] ha_fold;
  logic                  ha_flip;

  assign sample.ready = (state == S_IDLE);
  assign diff = sample.stamp_us - last_stamp;
  assign keep = seen_first && (diff > STAMP_W'(min_interval));
  assign ha   = ANG_W'($signed(heading));

  always_comb begin
    ha_flip = 1'b0;
    ha_fold = ha;
    if (ha > 17'sd16384) begin
      ha_fold = ha - 17'sd32768;
      ha_flip = 1'b1;
    end else if (ha < -17'sd16384) begin
      ha_fold = ha + 17'sd32768;
      ha_flip = 1'b1;
    end
  end

  // ------------------------------------------------------------------
  // CORDIC step
  logic signed [CORD_W-1:0] cx_sh, cy_sh, cx_n, cy_n;
  logic signed [ANG_W-1:0]  ca_n;

  always_comb begin
    cx_sh = cx >>> cnt[3:0];
    cy_sh = cy >>> cnt[3:0];
    if (ca >= 0) begin
      cx_n = cx - cy_sh;
      cy_n = cy + cx_sh;
      ca_n = ca - atan_units(cnt[3:0]);
    end else begin
      cx_n = cx + cy_sh;
      cy_n = cy - cx_sh;
      ca_n = ca + atan_units(cnt[3:0]);
    end
  end

  // ------------------------------------------------------------------
  // shared multiplier operands
  logic signed [24:0] mul_a;
  logic signed [20:0] mul_b;
  logic               full;
  logic [FILL_W-1:0]  factor;

  assign full   = (fill_count >= FILL_W'(WINDOW));
  assign factor = full ? FILL_W'(WINDOW) : fill_count + 1'b1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_ROT: begin
        unique case (cnt[2:0])
          3'd0:    begin mul_a = 25'(vx); mul_b = 21'(cx); end
          3'd1:    begin mul_a = 25'(vy); mul_b = 21'(cy); end
          3'd2:    begin mul_a = 25'(vx); mul_b = 21'(cy); end
          3'd3:    begin mul_a = 25'(vy); mul_b = 21'(cx); end
          default: ;
        endcase
      end
      S_SUMS: begin
        if (cnt[1:0] != 2'd3) begin
          mul_a = 25'(wv[cnt[1:0]]);
        end
        mul_b = $signed({{(21-FILL_W){1'b0}}, factor});
      end
      S_MULG: begin
        mul_a = 25'(mean);
        mul_b = $signed({5'b0, (ch == 2'd2) ? rot_gain : pos_gain});
      end
      S_MULT: begin
        mul_a = q;
        mul_b = $signed({1'b0, dt});
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // divider load and step
  logic signed [DIV_BITS-1:0] ld_num;
  logic [DIV_BITS-1:0]        ld_abs;
  logic [DEN_W-1:0]           ld_den;
  logic [DIV_BITS-1:0]        ld_mag;
  logic [DEN_W:0]             rem_sh;
  logic [DEN_W+1:0]           rem_diff;
  logic [DIV_BITS-1:0]        div_res;

  always_comb begin
    if (state == S_MSTART) begin
      ld_num = DIV_BITS'(weighted_sums[ch]);
      ld_den = DEN_W'(WSUM);
    end else begin
      ld_num = DIV_BITS'(prod);
      ld_den = (ch == 2'd2) ? DEN_W'(HEAD_DIV) : DEN_W'(POS_DIV);
    end
    ld_abs = ld_num[DIV_BITS-1] ? DIV_BITS'(-ld_num) : DIV_BITS'(ld_num);
    ld_mag = ld_abs + DIV_BITS'(ld_den >> 1);
  end

  assign rem_sh   = {div_rem, div_quo[DIV_BITS-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b0, div_den};
  assign div_res  = div_neg ? -div_quo : div_quo;

  // ------------------------------------------------------------------
  // rounding of mean * gain by 256
  logic [45:0] p_abs;
  logic [45:0] p_rnd;
  assign p_abs = prod[45] ? 46'(-prod) : 46'(prod);
  assign p_rnd = (p_abs + 46'd128) >> 8;

  // ------------------------------------------------------------------
  // pose update
  logic signed [POS_W:0]   nx, ny;
  logic signed [POS_W-1:0] sx, sy;

  assign nx = (POS_W+1)'(world_x) + (POS_W+1)'(steps[0]);
  assign ny = (POS_W+1)'(world_y) + (POS_W+1)'(steps[1]);
  assign sx = (nx > 33'sh07fffffff) ? 32'sh7fffffff :
              (nx < -33'sh080000000) ? 32'sh80000000 : nx[POS_W-1:0];
  assign sy = (ny > 33'sh07fffffff) ? 32'sh7fffffff :
              (ny < -33'sh080000000) ? 32'sh80000000 : ny[POS_W-1:0];

  assign out_load = (state == S_FIN) && (!out_valid || pose.ready);
  assign pose.valid = out_valid;

  // ------------------------------------------------------------------
  // window RAM: {turn, y, x} per slot
  assign ram_we = (state == S_SUMS) && (cnt[1:0] == 2'd3);

  owa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata ({wv[2], wv[1], wv[0]}),
    .raddr (write_slot),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------------
  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_gain     <= GAIN_W'(42598);
      rot_gain     <= GAIN_W'(36045);
      min_interval <= INTERVAL_W'(5000);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_POS_GAIN:     pos_gain     <= cfg_wdata[GAIN_W-1:0];
        REG_ROT_GAIN:     rot_gain     <= cfg_wdata[GAIN_W-1:0];
        REG_MIN_INTERVAL: min_interval <= cfg_wdata[INTERVAL_W-1:0];
        default:          ;
      endcase
    end
  end

  // multiplier output register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ------------------------------------------------------------------
  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      world_x      <= '0;
      world_y      <= '0;
      heading      <= '0;
      last_stamp   <= '0;
      seen_first   <= 1'b0;
      fill_count   <= '0;
      write_slot   <= '0;
      out_valid    <= 1'b0;
      cnt          <= '0;
      ch           <= '0;
      for (int k = 0; k < 3; k++) begin
        plain_sums[k]    <= '0;
        weighted_sums[k] <= '0;
      end
    end else begin
      if (pose.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            seen_first <= 1'b1;
            last_stamp <= sample.stamp_us;
            stamp      <= sample.stamp_us;
            vx         <= sample.body_vel_x;
            vy         <= sample.body_vel_y;
            wv[2]      <= sample.yaw_rate;
            dt         <= (diff > STAMP_W'(DT_MAX)) ? INTERVAL_W'(DT_MAX)
                                                    : diff[INTERVAL_W-1:0];
            cx         <= CORD_W'(CORDIC_START);
            cy         <= '0;
            ca         <= ha_fold;
            flip       <= ha_flip;
            cnt        <= '0;
            if (keep) begin
              state <= S_CORD;
            end
          end
        end

        S_CORD: begin
          ca <= ca_n;
          if (cnt[3:0] == 4'(CORDIC_STEPS - 1)) begin
            cx    <= flip ? -cx_n : cx_n;
            cy    <= flip ? -cy_n : cy_n;
            cnt   <= '0;
            state <= S_ROT;
          end else begin
            cx  <= cx_n;
            cy  <= cy_n;
            cnt <= cnt + 1'b1;
          end
        end

        // issue four products, consume each one in the cycle after it is issued
        S_ROT: begin
          cnt <= cnt + 1'b1;
          unique case (cnt[2:0])
            3'd1:    accx <= prod[33:0];
            3'd2:    accx <= accx - $signed(prod[33:0]);
            3'd3:    accy <= prod[33:0];
            3'd4:    accy <= accy + $signed(prod[33:0]);
            default: ;
          endcase
          if (cnt[2:0] == 3'd4) begin
            state <= S_RND;
          end
        end

        S_RND: begin
          wv[0]   <= sat_round14(accx);
          wv[1]   <= sat_round14(accy);
          old_row <= ram_rdata;
          cnt     <= '0;
          state   <= S_SUMS;
        end

        S_SUMS: begin
          cnt <= cnt + 1'b1;
          if (cnt[1:0] != 2'd0) begin
            if (full) begin
              weighted_sums[cnt[1:0] - 2'd1] <= weighted_sums[cnt[1:0] - 2'd1]
                  - 36'(plain_sums[cnt[1:0] - 2'd1]) + $signed(prod[35:0]);
              plain_sums[cnt[1:0] - 2'd1] <= plain_sums[cnt[1:0] - 2'd1]
                  + 25'(wv[cnt[1:0] - 2'd1])
                  - 25'($signed(old_row[(cnt[1:0] - 2'd1) * RATE_W +: RATE_W]));
            end else begin
              weighted_sums[cnt[1:0] - 2'd1] <= weighted_sums[cnt[1:0] - 2'd1]
                  + $signed(prod[35:0]);
              plain_sums[cnt[1:0] - 2'd1] <= plain_sums[cnt[1:0] - 2'd1]
                  + 25'(wv[cnt[1:0] - 2'd1]);
            end
          end
          if (cnt[1:0] == 2'd3) begin
            write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0
                                                              : write_slot + 1'b1;
            ch <= '0;
            if (full) begin
              state <= S_MSTART;
            end else begin
              fill_count <= fill_count + 1'b1;
              state      <= S_IDLE;
            end
          end
        end

        S_MSTART, S_SSTART: begin
          div_neg <= ld_num[DIV_BITS-1];
          div_quo <= ld_mag;
          div_rem <= '0;
          div_den <= ld_den;
          cnt     <= '0;
          state   <= (state == S_MSTART) ? S_MDIV : S_SDIV;
        end

        S_MDIV, S_SDIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(DIV_BITS)) begin
            // quotient complete, last cycle only collects it
            if (state == S_MDIV) begin
              mean  <= div_res[17:0];
              state <= S_MULG;
            end else begin
              steps[ch] <= div_res[23:0];
              if (ch == 2'd2) begin
                state <= S_FIN;
              end else begin
                ch    <= ch + 1'b1;
                state <= S_MSTART;
              end
            end
          end else if (!rem_diff[DEN_W+1]) begin
            div_rem <= rem_diff[DEN_W-1:0];
            div_quo <= {div_quo[DIV_BITS-2:0], 1'b1};
          end else begin
            div_rem <= rem_sh[DEN_W-1:0];
            div_quo <= {div_quo[DIV_BITS-2:0], 1'b0};
          end
        end

        S_MULG: state <= S_MQ;

        S_MQ: begin
          q     <= prod[45] ? -$signed(p_rnd[24:0]) : $signed(p_rnd[24:0]);
          state <= S_MULT;
        end

        S_MULT: state <= S_SSTART;

        S_FIN: begin
          if (out_load) begin
            world_x            <= sx;
            world_y            <= sy;
            heading            <= heading + steps[2][HEAD_W-1:0];
            pose.pose_x        <= sx;
            pose.pose_y        <= sy;
            pose.pose_heading  <= heading + steps[2][HEAD_W-1:0];
            pose.pose_stamp_us <= stamp;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // assertions
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WINDOW))
    else $error("fill count beyond window");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot < SLOT_W'(WINDOW))
    else $error("write slot out of range");

  a_pose_full: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (fill_count == FILL_W'(WINDOW)))
    else $error("pose emitted before window filled");

  a_pose_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> pose.valid)
    else $error("pose transaction lost");

  a_slot_fill: assert property (@(posedge clk) disable iff (rst)
    (fill_count != FILL_W'(WINDOW)) |-> (FILL_W'(write_slot) == fill_count))
    else $error("slot and fill count disagree while filling");

endmodule
`default_nettype wire
